>>> hdl/tof_hit_word_histogrammer_assert.svh
// ----------------------------------------------------------------------------
// tof hit word histogrammer assertion macros
// concurrent property wrappers shared by the checker
// ----------------------------------------------------------------------------
`ifndef TOF_HIT_WORD_HISTOGRAMMER_ASSERT_SVH
`define TOF_HIT_WORD_HISTOGRAMMER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TOFH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tofh: property violated");

// next-cycle implication, disabled during reset
`define TOFH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tofh: property violated");

`endif

>>> hdl/tofh_pkg.sv
// ----------------------------------------------------------------------------
// tofh_pkg
// shared types and constants of the tof hit word histogrammer
// ----------------------------------------------------------------------------
`default_nettype none

package tofh_pkg;

    localparam int CHANNELS = 192;

    // command codes
    localparam logic [1:0] CMD_DATA     = 2'd0;
    localparam logic [1:0] CMD_READ     = 2'd1;
    localparam logic [1:0] CMD_READ_CLR = 2'd2;

    // word types of interest
    localparam logic [3:0] WT_LEAD  = 4'h4;
    localparam logic [3:0] WT_TRAIL = 4'h5;
    localparam logic [3:0] WT_GEO   = 4'hC;

    typedef enum logic [2:0] {
        KIND_SKIP  = 3'd0,
        KIND_GEO   = 3'd1,
        KIND_LEAD  = 3'd2,
        KIND_TRAIL = 3'd3,
        KIND_READ  = 3'd4,
        KIND_DROP  = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_INC,
        WR_CLR
    } wr_mode_t;

endpackage

`default_nettype wire

>>> hdl/tof_hit_word_histogrammer.sv
// ----------------------------------------------------------------------------
// tof_hit_word_histogrammer
// counts leading and trailing edge hits per tray and channel in one ram
// ----------------------------------------------------------------------------
// path: an accepted input is decoded and its ram read issued into stage 1; the count
//   is then modified, written back and loaded into the output register that drives m_*
// throughput: one transaction per cycle unless clearing or stalled; the single ram write
//   port: one read-modify-write per cycle; back-to-back same-counter hits are forwarded
// reset: synchronous active-low; afterwards the counter ram is zeroed one entry
//   per cycle over all 2*NUM_TRAYS*192 entries (11520 by default), with s_tready low
// ----------------------------------------------------------------------------
`default_nettype none

module tof_hit_word_histogrammer
    import tofh_pkg::*;
#(
    parameter int NUM_TRAYS = 30
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // configuration: first_tray
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_wdata,

    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // data_word[31:0], start_of_event[32], read_edge[33], read_tray[38:34],
    // read_channel[46:39], zero[47]
    input  wire logic [47:0] s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_tuser,

    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // hit_tray[4:0], hit_channel[12:5], count[44:13], zero[47:45]
    output logic      [47:0] m_tdata,
    // kind[2:0]
    output logic      [2:0]  m_tuser
);

    localparam int HALF  = NUM_TRAYS * CHANNELS;   // entries per edge
    localparam int DEPTH = 2 * HALF;
    localparam int AW    = $clog2(DEPTH);

    // ------------------------------------------------------------------
    // input field split
    // ------------------------------------------------------------------
    logic [1:0]  in_cmd;
    logic [31:0] in_word;
    logic        in_sof;
    logic        in_redge;
    logic [4:0]  in_rtray;
    logic [7:0]  in_rchan;
    logic [3:0]  in_type;

    assign in_cmd   = s_tuser;
    assign in_word  = s_tdata[31:0];
    assign in_sof   = s_tdata[32];
    assign in_redge = s_tdata[33];
    assign in_rtray = s_tdata[38:34];
    assign in_rchan = s_tdata[46:39];
    assign in_type  = in_word[31:28];

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [6:0]  first_tray_reg,  first_tray_next;
    logic [6:0]  cur_tray_reg,    cur_tray_next;
    logic        cur_half_reg,    cur_half_next;
    logic        tray_known_reg,  tray_known_next;

    logic          clr_active_reg, clr_active_next;
    logic [AW-1:0] clr_addr_reg,   clr_addr_next;

    // stage 1: ram read in flight
    logic          st1_valid_reg, st1_valid_next;
    kind_t         st1_kind_reg,  st1_kind_next;
    logic [4:0]    st1_tray_reg,  st1_tray_next;
    logic [7:0]    st1_chan_reg,  st1_chan_next;
    logic [AW-1:0] st1_addr_reg,  st1_addr_next;
    wr_mode_t      st1_wr_reg,    st1_wr_next;
    logic          st1_rd_reg,    st1_rd_next;
    logic          fwd_valid_reg, fwd_valid_next;
    logic [31:0]   fwd_data_reg,  fwd_data_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    kind_t         out_kind_reg,  out_kind_next;
    logic [4:0]    out_tray_reg,  out_tray_next;
    logic [7:0]    out_chan_reg,  out_chan_next;
    logic [31:0]   out_count_reg, out_count_next;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic st1_adv;
    logic s_accept;

    assign st1_adv  = st1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clr_active_reg && (!st1_valid_reg || st1_adv);
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // decode of the incoming transaction
    // ------------------------------------------------------------------
    logic          known_eff;
    logic          in_window;
    logic [6:0]    tray_idx;
    logic [7:0]    hit_chan;
    logic          hit_edge;
    logic [AW-1:0] hit_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_in_range;

    kind_t         dec_kind;
    logic [4:0]    dec_tray;
    logic [7:0]    dec_chan;
    logic [AW-1:0] dec_addr;
    wr_mode_t      dec_wr;
    logic          dec_rd;

    // start-of-event forgets the tray before the word is looked at
    assign known_eff = tray_known_reg && !in_sof;
    assign in_window = (cur_tray_reg >= first_tray_reg) &&
                       ({1'b0, cur_tray_reg} < ({1'b0, first_tray_reg} + 8'(NUM_TRAYS)));
    assign tray_idx  = cur_tray_reg - first_tray_reg;

    // channel = sub + (tdc mod 4)*8 + (tdc div 4)*24 + 96*half
    assign hit_chan = 8'(in_word[23:21])
                    + {3'b0, in_word[25:24], 3'b0}
                    + {2'b0, in_word[27:26], 4'b0}
                    + {3'b0, in_word[27:26], 3'b0}
                    + (cur_half_reg ? 8'd96 : 8'd0);
    assign hit_edge = (in_type == WT_TRAIL);

    assign hit_addr = (hit_edge ? AW'(HALF) : AW'(0))
                    + AW'(tray_idx) * AW'(CHANNELS)
                    + AW'(hit_chan);
    assign rd_addr  = (in_redge ? AW'(HALF) : AW'(0))
                    + AW'(in_rtray) * AW'(CHANNELS)
                    + AW'(in_rchan);
    assign rd_in_range = ({2'b0, in_rtray} < 7'(NUM_TRAYS)) &&
                         (in_rchan < 8'(CHANNELS));

    always_comb begin
        dec_kind = KIND_SKIP;
        dec_tray = '0;
        dec_chan = '0;
        dec_addr = hit_addr;
        dec_wr   = WR_NONE;
        dec_rd   = 1'b0;
        case (in_cmd)
            CMD_READ, CMD_READ_CLR: begin
                dec_kind = KIND_READ;
                dec_addr = rd_addr;
                if (rd_in_range) begin
                    dec_rd = 1'b1;
                    if (in_cmd == CMD_READ_CLR) begin
                        dec_wr = WR_CLR;
                    end
                end
            end
            CMD_DATA: begin
                if (in_type == WT_GEO) begin
                    dec_kind = KIND_GEO;
                end else if ((in_type == WT_LEAD || in_type == WT_TRAIL) &&
                             known_eff && in_window) begin
                    dec_chan = hit_chan;
                    if (hit_chan >= 8'(CHANNELS)) begin
                        dec_kind = KIND_DROP;
                    end else begin
                        dec_kind = hit_edge ? KIND_TRAIL : KIND_LEAD;
                        dec_tray = tray_idx[4:0];
                        dec_wr   = WR_INC;
                    end
                end
            end
            default: begin
                dec_kind = KIND_SKIP;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // counter ram: clear sweep after reset, else stage 1 write-back
    // ------------------------------------------------------------------
    logic [31:0]   ram_rdata;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [31:0]   cur_count;
    logic [31:0]   new_count;
    logic          st1_writes;

    // forwarded value covers a read issued while the previous item wrote the same entry
    assign cur_count  = fwd_valid_reg ? fwd_data_reg : ram_rdata;
    assign new_count  = (st1_wr_reg == WR_INC) ?
                        ((cur_count == 32'hFFFF_FFFF) ? cur_count : cur_count + 32'd1) :
                        32'd0;
    assign st1_writes = st1_adv && (st1_wr_reg != WR_NONE);

    assign ram_we    = clr_active_reg || st1_writes;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : st1_addr_reg;
    assign ram_wdata = clr_active_reg ? 32'd0 : new_count;

    tofh_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_counts (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (dec_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        first_tray_next = cfg_we ? cfg_wdata : first_tray_reg;

        cur_tray_next   = cur_tray_reg;
        cur_half_next   = cur_half_reg;
        tray_known_next = tray_known_reg;
        if (s_accept && in_cmd == CMD_DATA) begin
            if (in_sof) begin
                tray_known_next = 1'b0;
            end
            if (in_type == WT_GEO) begin
                cur_tray_next   = in_word[7:1];
                cur_half_next   = in_word[0];
                tray_known_next = 1'b1;
            end
        end

        // clear sweep
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg) begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_active_next = 1'b0;
            end
        end

        // stage 1 load
        st1_valid_next = s_accept || (st1_valid_reg && !st1_adv);
        st1_kind_next  = st1_kind_reg;
        st1_tray_next  = st1_tray_reg;
        st1_chan_next  = st1_chan_reg;
        st1_addr_next  = st1_addr_reg;
        st1_wr_next    = st1_wr_reg;
        st1_rd_next    = st1_rd_reg;
        fwd_valid_next = fwd_valid_reg;
        fwd_data_next  = fwd_data_reg;
        if (s_accept) begin
            st1_kind_next  = dec_kind;
            st1_tray_next  = dec_tray;
            st1_chan_next  = dec_chan;
            st1_addr_next  = dec_addr;
            st1_wr_next    = dec_wr;
            st1_rd_next    = dec_rd;
            fwd_valid_next = st1_writes && (st1_addr_reg == dec_addr);
            fwd_data_next  = new_count;
        end

        // output register
        out_valid_next = st1_adv || (out_valid_reg && !m_tready);
        out_kind_next  = out_kind_reg;
        out_tray_next  = out_tray_reg;
        out_chan_next  = out_chan_reg;
        out_count_next = out_count_reg;
        if (st1_adv) begin
            out_kind_next  = st1_kind_reg;
            out_tray_next  = st1_tray_reg;
            out_chan_next  = st1_chan_reg;
            out_count_next = st1_rd_reg ? cur_count : 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_tray_reg <= 7'd1;
            cur_tray_reg   <= '0;
            cur_half_reg   <= 1'b0;
            tray_known_reg <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            st1_valid_reg  <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            first_tray_reg <= first_tray_next;
            cur_tray_reg   <= cur_tray_next;
            cur_half_reg   <= cur_half_next;
            tray_known_reg <= tray_known_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            st1_valid_reg  <= st1_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        // payload, no reset
        st1_kind_reg  <= st1_kind_next;
        st1_tray_reg  <= st1_tray_next;
        st1_chan_reg  <= st1_chan_next;
        st1_addr_reg  <= st1_addr_next;
        st1_wr_reg    <= st1_wr_next;
        st1_rd_reg    <= st1_rd_next;
        fwd_data_reg  <= fwd_data_next;
        out_kind_reg  <= out_kind_next;
        out_tray_reg  <= out_tray_next;
        out_chan_reg  <= out_chan_next;
        out_count_reg <= out_count_next;
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {3'b0, out_count_reg, out_chan_reg, out_tray_reg};

endmodule

`default_nettype wire

>>> hdl/tofh_ram.sv
// ----------------------------------------------------------------------------
// tofh_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tofh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/tofh_checker.sv
// ----------------------------------------------------------------------------
// tofh_checker
// port-level properties of the tof hit word histogrammer
// ----------------------------------------------------------------------------
`default_nettype none

`include "tof_hit_word_histogrammer_assert.svh"

module tofh_checker
    import tofh_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    // stalled result holds
    `TOFH_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // counter ram is being cleared right after reset
    `TOFH_ASSERT_IMPL(a_clear_after_reset, aclk, aresetn, $rose(aresetn), !s_tready)

    // only read transactions carry a count
    `TOFH_ASSERT_IMPL(a_count_only_read, aclk, aresetn, m_tvalid && (m_tuser != KIND_READ), m_tdata[44:13] == 32'd0)

    // dropped hit has an out-of-range channel and no tray
    `TOFH_ASSERT_IMPL(a_drop_fields, aclk, aresetn, m_tvalid && (m_tuser == KIND_DROP), (m_tdata[12:5] >= 8'(CHANNELS)) && (m_tdata[4:0] == 5'd0))

    // counted hit has an in-range channel
    `TOFH_ASSERT_IMPL(a_hit_chan, aclk, aresetn, m_tvalid && (m_tuser == KIND_LEAD || m_tuser == KIND_TRAIL), m_tdata[12:5] < 8'(CHANNELS))

endmodule

bind tof_hit_word_histogrammer tofh_checker u_tofh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the tof hit word histogrammer against a cycle-free predictor of its
// per-tray, per-channel edge counters; directed decode and read cases first,
// then random word streams under several idle and stall mixes
// ----------------------------------------------------------------------------
module tb;
    import tofh_pkg::*;

    localparam int NUM_TRAYS = 30;
    localparam int STORE_DEPTH = 2 * NUM_TRAYS * CHANNELS;
    localparam int RUN_LIMIT = 400000;

    // command code that the block leaves unused
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // word types that the block skips without touching the counters
    localparam logic [4:0][3:0] SKIP_TYPES = {4'h2, 4'hD, 4'hE, 4'hA, 4'h6};

    typedef struct {
        kind_t       kind;
        logic [4:0]  tray;
        logic [7:0]  chan;
        logic [31:0] count;
    } hist_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    // data_word[31:0], start_of_event[32], read_edge[33], read_tray[38:34],
    // read_channel[46:39], zero[47]
    logic [47:0] s_tdata;
    // cmd[1:0]
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // hit_tray[4:0], hit_channel[12:5], count[44:13], zero[47:45]
    logic [47:0] m_tdata;
    // kind[2:0]
    logic [2:0]  m_tuser;

    // predictor copy of the counters, the tray tracking and the window register
    logic [31:0]  counter_model [0:STORE_DEPTH-1];
    int           cur_tray = 0;
    logic         cur_half = 1'b0;
    logic         tray_known = 1'b0;
    int           first_tray = 1;
    hist_result_t pending_results[$];

    // coordinates of the last counted hit, used to aim random reads
    int last_tidx = 0;
    int last_chan = 0;
    int last_edge = 0;

    int mismatches = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    logic sink_hold = 1'b0;

    // transactions taken by the block and results checked so far
    int sent_count = 0;
    int checked_count = 0;

    tof_hit_word_histogrammer #(
        .NUM_TRAYS(NUM_TRAYS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // predictor: one expected result per accepted input transaction
    // ------------------------------------------------------------------------
    function automatic void predict_word(input logic [1:0] cmd, input logic [47:0] d);
        hist_result_t r;
        logic [31:0]  word;
        logic [3:0]   wtype;
        int           rtray;
        int           rchan;
        int           addr;
        int           chan;
        int           tidx;
        int           edge_sel;
        word = d[31:0];
        wtype = word[31:28];
        rtray = int'(d[38:34]);
        rchan = int'(d[46:39]);
        r.kind = KIND_SKIP;
        r.tray = '0;
        r.chan = '0;
        r.count = '0;
        if (cmd == CMD_READ || cmd == CMD_READ_CLR) begin
            r.kind = KIND_READ;
            // out-of-range reads return zero and clear nothing
            if (rtray < NUM_TRAYS && rchan < CHANNELS) begin
                edge_sel = int'(d[33]);
                addr = edge_sel * NUM_TRAYS * CHANNELS + rtray * CHANNELS + rchan;
                r.count = counter_model[addr];
                if (cmd == CMD_READ_CLR) begin
                    counter_model[addr] = '0;
                end
            end
        end else if (cmd == CMD_DATA) begin
            // start of event forgets the tray before the word is looked at
            if (d[32]) begin
                tray_known = 1'b0;
            end
            if (wtype == WT_GEO) begin
                cur_half = word[0];
                cur_tray = int'(word[7:1]);
                tray_known = 1'b1;
                r.kind = KIND_GEO;
            end else if ((wtype == WT_LEAD || wtype == WT_TRAIL) && tray_known &&
                         cur_tray >= first_tray && cur_tray < first_tray + NUM_TRAYS) begin
                chan = int'(word[23:21]) + int'(word[25:24]) * 8 + int'(word[27:26]) * 24 +
                       (cur_half ? 96 : 0);
                tidx = cur_tray - first_tray;
                r.chan = chan[7:0];
                if (chan >= CHANNELS) begin
                    r.kind = KIND_DROP;
                end else begin
                    edge_sel = (wtype == WT_TRAIL) ? 1 : 0;
                    addr = edge_sel * NUM_TRAYS * CHANNELS + tidx * CHANNELS + chan;
                    // counters saturate at all ones
                    if (counter_model[addr] != 32'hFFFF_FFFF) begin
                        counter_model[addr] = counter_model[addr] + 32'd1;
                    end
                    r.kind = edge_sel ? KIND_TRAIL : KIND_LEAD;
                    r.tray = tidx[4:0];
                    last_tidx = tidx;
                    last_chan = chan;
                    last_edge = edge_sel;
                end
            end
        end
        pending_results.push_back(r);
    endfunction

    // input side monitor: values sampled at the edge are the pre-edge ones
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_word(s_tuser, s_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : check_results
        hist_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            checked_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result transaction, kind", 32'(m_tuser), '0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind) begin
                    report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
                end
                if (m_tdata[4:0] !== want.tray) begin
                    report_mismatch("hit_tray", 32'(m_tdata[4:0]), 32'(want.tray));
                end
                if (m_tdata[12:5] !== want.chan) begin
                    report_mismatch("hit_channel", 32'(m_tdata[12:5]), 32'(want.chan));
                end
                if (m_tdata[44:13] !== want.count) begin
                    report_mismatch("count", m_tdata[44:13], want.count);
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off while sink_hold is set
    always @(posedge aclk) begin
        if (sink_hold) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // called just after a rising edge; returns at the edge that took the item
    task automatic send_item(input logic [1:0] cmd, input logic [31:0] word, input logic sof,
                             input logic rd_edge, input logic [4:0] rtray,
                             input logic [7:0] rchan);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {1'b0, rchan, rtray, rd_edge, sof, word};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    task automatic send_data(input logic [31:0] word, input logic sof);
        send_item(CMD_DATA, word, sof, 1'b0, 5'd0, 8'd0);
    endtask

    // reads carry random data words and start flags, which must be ignored
    task automatic send_read(input logic [1:0] cmd, input logic rd_edge,
                             input logic [4:0] rtray, input logic [7:0] rchan);
        send_item(cmd, $urandom(), 1'($urandom_range(1)), rd_edge, rtray, rchan);
    endtask

    function automatic logic [31:0] geo_word(input logic [6:0] tray, input logic half);
        geo_word = {WT_GEO, 20'h0, tray, half};
    endfunction

    function automatic logic [31:0] hit_word(input logic [3:0] wtype, input logic [3:0] tdc,
                                             input logic [2:0] sub);
        hit_word = {wtype, tdc, sub, 21'h0};
    endfunction

    // stop offering and wait until every accepted transaction has its result back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (checked_count != sent_count) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // window register is only written with the block idle
    task automatic set_first_tray(input logic [6:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        first_tray = int'(value);
    endtask

    task automatic random_burst(input int n);
        int          pick;
        logic [31:0] w;
        logic [6:0]  t;
        logic [1:0]  rcmd;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            w = $urandom();
            rcmd = ($urandom_range(3) == 0) ? CMD_READ_CLR : CMD_READ;
            if (pick < 12) begin
                // geographic word, mostly a tray at the low end of the window
                if ($urandom_range(3) == 0) begin
                    t = w[7:1];
                end else begin
                    t = 7'(first_tray + $urandom_range(3));
                end
                w[31:28] = WT_GEO;
                w[7:1] = t;
                send_data(w, $urandom_range(9) == 0);
            end else if (pick < 60) begin
                w[31:28] = $urandom_range(1) ? WT_TRAIL : WT_LEAD;
                send_data(w, $urandom_range(19) == 0);
            end else if (pick < 78) begin
                if ($urandom_range(3) != 0) begin
                    send_read(rcmd, last_edge[0], last_tidx[4:0], last_chan[7:0]);
                end else begin
                    send_read(rcmd, 1'($urandom_range(1)), 5'($urandom_range(31)),
                              8'($urandom_range(255)));
                end
            end else if (pick < 90) begin
                w[31:28] = SKIP_TYPES[$urandom_range(4)];
                send_data(w, 1'($urandom_range(1)));
            end else begin
                // anything at all, unused command included
                send_item(2'($urandom_range(3)), w, 1'($urandom_range(1)),
                          1'($urandom_range(1)), 5'($urandom_range(31)),
                          8'($urandom_range(255)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // word decode: unknown tray, window bounds, channel math, drops, start flag
    task automatic test_hit_decode();
        set_first_tray(7'd1);
        send_data(hit_word(WT_LEAD, 4'd0, 3'd0), 1'b0);
        send_data(geo_word(7'd1, 1'b0), 1'b0);
        send_data(hit_word(WT_LEAD, 4'd0, 3'd0), 1'b0);
        send_data(hit_word(WT_TRAIL, 4'd15, 3'd7), 1'b0);
        send_data(geo_word(7'd30, 1'b1), 1'b0);
        send_data(hit_word(WT_LEAD, 4'd15, 3'd7), 1'b0);
        send_data(hit_word(WT_TRAIL, 4'd12, 3'd0), 1'b0);
        send_data(geo_word(7'd31, 1'b0), 1'b0);
        send_data(hit_word(WT_LEAD, 4'd1, 3'd1), 1'b0);
        send_data(geo_word(7'd0, 1'b1), 1'b0);
        send_data(hit_word(WT_LEAD, 4'd1, 3'd1), 1'b0);
        send_data(geo_word(7'd2, 1'b0), 1'b0);
        send_data(hit_word(WT_LEAD, 4'd5, 3'd3), 1'b1);
        send_data(geo_word(7'd2, 1'b1), 1'b1);
        send_data(hit_word(WT_LEAD, 4'd5, 3'd3), 1'b0);
        for (int i = 0; i < 5; i++) begin
            send_data({SKIP_TYPES[i], 28'hFFF_FFFF}, 1'b0);
        end
        send_data(32'h0000_0000, 1'b0);
        send_data(32'hFFFF_FFFF, 1'b1);
        drain();
    endtask

    // reads, read-and-clear, out-of-range reads and the unused command
    task automatic test_count_reads();
        send_read(CMD_READ, 1'b0, 5'd0, 8'd0);
        send_read(CMD_READ_CLR, 1'b1, 5'd0, 8'd103);
        send_read(CMD_READ, 1'b1, 5'd0, 8'd103);
        send_read(CMD_READ, 1'b1, 5'd29, 8'd168);
        send_read(CMD_READ, 1'b0, 5'd31, 8'd0);
        send_read(CMD_READ_CLR, 1'b0, 5'd0, 8'd255);
        send_read(CMD_READ, 1'b0, 5'd30, 8'd192);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 5'h1F, 8'hFF);
        // a start flag on a read must not forget the tray
        send_item(CMD_READ, 32'hFFFF_FFFF, 1'b1, 1'b0, 5'd0, 8'd0);
        send_data(hit_word(WT_LEAD, 4'd0, 3'd0), 1'b0);
        send_read(CMD_READ_CLR, 1'b0, 5'd1, 8'd96);
        drain();
    endtask

    // window register at its extremes and at the top-aligned position
    task automatic test_window_edges();
        set_first_tray(7'd0);
        send_data(geo_word(7'd0, 1'b0), 1'b0);
        send_data(hit_word(WT_LEAD, 4'd3, 3'd2), 1'b0);
        send_data(geo_word(7'd29, 1'b1), 1'b0);
        send_data(hit_word(WT_TRAIL, 4'd9, 3'd4), 1'b0);
        send_data(geo_word(7'd30, 1'b0), 1'b0);
        send_data(hit_word(WT_LEAD, 4'd3, 3'd2), 1'b0);
        send_read(CMD_READ, 1'b0, 5'd0, 8'd26);
        set_first_tray(7'd127);
        send_data(geo_word(7'd127, 1'b1), 1'b0);
        send_data(hit_word(WT_LEAD, 4'd0, 3'd0), 1'b0);
        send_data(geo_word(7'd126, 1'b1), 1'b0);
        send_data(hit_word(WT_LEAD, 4'd0, 3'd0), 1'b0);
        send_read(CMD_READ, 1'b0, 5'd0, 8'd96);
        set_first_tray(7'd98);
        send_data(geo_word(7'd127, 1'b0), 1'b0);
        send_data(hit_word(WT_TRAIL, 4'd7, 3'd7), 1'b0);
        send_read(CMD_READ_CLR, 1'b1, 5'd29, 8'd47);
        drain();
    endtask

    // random streams under each idle/stall mix, with a new window each time
    task automatic test_random_phases();
        set_first_tray(7'd1);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        random_burst(180);
        set_first_tray(7'($urandom_range(127)));
        src_idle_pct = 60;
        sink_stall_pct = 0;
        random_burst(180);
        set_first_tray(7'd0);
        src_idle_pct = 0;
        sink_stall_pct = 60;
        random_burst(180);
        set_first_tray(7'd98);
        src_idle_pct = 24;
        sink_stall_pct = 24;
        random_burst(180);
        drain();
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_input_backpressure();
        set_first_tray(7'd1);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (300) @(posedge aclk);
                sink_hold <= 1'b0;
            end
        join_none
        random_burst(80);
        drain();
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            counter_model[i] = '0;
        end
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        // the counter clearing pass after reset shows up as s_tready low
        test_hit_decode();
        test_count_reads();
        test_window_edges();
        test_random_phases();
        test_input_backpressure();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // hang guard, far beyond the clearing pass plus the slowest stall mix
    initial begin
        #(RUN_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/tofh_pkg.sv
hdl/tofh_ram.sv
hdl/tof_hit_word_histogrammer.sv
hdl/tofh_checker.sv
bench/tb.sv
